// ----- design/sb2dec_pkg.sv -----
package sb2dec_pkg;

    // Field widths of the ports.
    localparam int VALUE_W = 33;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 4;

    // The magnitude of a 33-bit two's complement value needs 33 bits and at most ten digits.
    localparam int MAG_W      = 33;
    localparam int MAG_DIGITS = 10;

    // Default size of the digit buffer.
    localparam int MAX_DIGITS_DEF = 10;

    // Shift-and-add-3 conversion, several magnitude bits per clock.
    localparam int STEP_BITS   = 4;
    localparam int SHIFT_STEPS = (MAG_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W       = SHIFT_STEPS * STEP_BITS;
    localparam int STEP_CNT_W  = $clog2(SHIFT_STEPS);

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic shift;
        logic count;
        logic emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic final_char;
    } ctl_stat_t;

    // Largest magnitude that fits in the given number of digits: all nines.
    function automatic logic [63:0] digit_limit(input int max_digits);
        int          d;
        logic [63:0] lim;
        d = max_digits;
        if (d < 1)
        begin
            d = 1;
        end
        if (d > 19)
        begin
            d = 19;
        end
        lim = 64'd1;
        for (int i = 0; i < d; i++)
        begin
            lim = lim * 64'd10;
        end
        return lim - 64'd1;
    endfunction

endpackage

// ----- design/sb2dec_ctrl.sv -----
module sb2dec_ctrl
    import sb2dec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_COUNT = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(SHIFT_STEPS - 1);

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [STEP_CNT_W-1:0] step_reg;
    logic [STEP_CNT_W-1:0] step_next;

    // A new value is taken only when the previous one has been handed to the output register.
    assign in_ready  = (state_reg == ST_IDLE);
    assign cmd.load  = in_valid && in_ready;
    assign cmd.shift = (state_reg == ST_CONV);
    assign cmd.count = (state_reg == ST_COUNT);
    assign cmd.emit  = (state_reg == ST_EMIT) && stat.out_free;

    // Next state and conversion step counter.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (cmd.load)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (cmd.emit && stat.final_char)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- design/sb2dec_dpath.sv -----
module sb2dec_dpath
    import sb2dec_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VALUE_W-1:0] value,
    input  ctl_cmd_t           cmd,
    output ctl_stat_t          stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  character,
    output logic               last,
    output logic [COUNT_W-1:0] char_count
);

    localparam int BCD_DIGITS = (MAX_DIGITS < MAG_DIGITS) ? MAX_DIGITS : MAG_DIGITS;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int IDX_W      = (BCD_DIGITS > 1) ? $clog2(BCD_DIGITS) : 1;
    localparam logic [63:0] LIMIT = digit_limit(MAX_DIGITS);

    logic               neg_reg,       neg_next;
    logic [PAD_W-1:0]   sh_reg,        sh_next;
    logic [BCD_W-1:0]   bcd_reg,       bcd_next;
    logic [IDX_W-1:0]   idx_reg,       idx_next;
    logic               sign_pend_reg, sign_pend_next;
    logic [COUNT_W-1:0] total_reg,     total_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg,      char_next;
    logic               last_reg,      last_next;
    logic [COUNT_W-1:0] count_reg,     count_next;

    logic [MAG_W-1:0]   mag;
    logic [MAG_W-1:0]   mag_sat;
    logic [BCD_W-1:0]   bcd_step;
    logic [PAD_W-1:0]   sh_step;
    logic [IDX_W-1:0]   top_idx;
    logic [3:0]         cur_digit;
    logic               digit_final;

    // Magnitude of the incoming value, held to what the digit buffer can show.
    always_comb
    begin
        mag = value[VALUE_W-1] ? (MAG_W'(0) - MAG_W'(value)) : MAG_W'(value);
        if (64'(mag) > LIMIT)
        begin
            mag_sat = LIMIT[MAG_W-1:0];
        end
        else
        begin
            mag_sat = mag;
        end
    end

    // Several rounds of add-3 correction and shift per clock.
    always_comb
    begin
        bcd_step = bcd_reg;
        sh_step  = sh_reg;
        for (int j = 0; j < STEP_BITS; j++)
        begin
            for (int k = 0; k < BCD_DIGITS; k++)
            begin
                if (bcd_step[4*k +: 4] >= 4'd5)
                begin
                    bcd_step[4*k +: 4] = bcd_step[4*k +: 4] + 4'd3;
                end
            end
            bcd_step = {bcd_step[BCD_W-2:0], sh_step[PAD_W-1]};
            sh_step  = {sh_step[PAD_W-2:0], 1'b0};
        end
    end

    // Position of the most significant non-zero digit; zero keeps a single digit.
    always_comb
    begin
        top_idx = '0;
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] != 4'd0)
            begin
                top_idx = IDX_W'(k);
            end
        end
    end

    assign cur_digit   = bcd_reg[4*idx_reg +: 4];
    assign digit_final = !sign_pend_reg && (idx_reg == '0);

    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.final_char = digit_final;

    // Next values of the working registers and of the output register.
    always_comb
    begin
        neg_next       = neg_reg;
        sh_next        = sh_reg;
        bcd_next       = bcd_reg;
        idx_next       = idx_reg;
        sign_pend_next = sign_pend_reg;
        total_next     = total_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            neg_next = value[VALUE_W-1];
            sh_next  = PAD_W'(mag_sat);
            bcd_next = '0;
        end

        if (cmd.shift)
        begin
            sh_next  = sh_step;
            bcd_next = bcd_step;
        end

        if (cmd.count)
        begin
            idx_next       = top_idx;
            sign_pend_next = neg_reg;
            total_next     = COUNT_W'(top_idx) + COUNT_W'(1) + COUNT_W'(neg_reg);
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (sign_pend_reg)
            begin
                char_next      = CHAR_MINUS;
                last_next      = 1'b0;
                count_next     = '0;
                sign_pend_next = 1'b0;
            end
            else
            begin
                char_next  = CHAR_ZERO + CHAR_W'(cur_digit);
                last_next  = digit_final;
                count_next = digit_final ? total_reg : '0;
                if (!digit_final)
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        sh_reg        <= sh_next;
        bcd_reg       <= bcd_next;
        idx_reg       <= idx_next;
        sign_pend_reg <= sign_pend_next;
        total_reg     <= total_next;
        char_reg      <= char_next;
        last_reg      <= last_next;
        count_reg     <= count_next;
    end

    assign out_valid  = out_valid_reg;
    assign character  = char_reg;
    assign last       = last_reg;
    assign char_count = count_reg;

    // A closing beat carries a count, every other beat carries none.
    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> count_reg != '0)
        else $error("closing beat has no character count");

    a_no_count_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> count_reg == '0)
        else $error("character count on a beat that does not close the run");

    // The run always closes on a digit, never on the minus sign.
    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> char_reg >= CHAR_ZERO && char_reg <= CHAR_ZERO + 8'd9)
        else $error("run closes on a character that is not a digit");

    // The output register is only loaded when it is free.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg || out_ready)
        else $error("output beat overwritten before it was taken");

endmodule

// ----- design/signed_binary_to_decimal_ascii_core.sv -----
// Prints one 33-bit two's complement value per input beat as decimal ASCII text, one character
// per output beat: a minus sign for negative values, then the digits most significant first with
// no leading zeros, and a single '0' for zero. The closing beat has last set and carries the
// number of characters in the run in char_count; every other beat has char_count at zero. A value
// passes from acceptance to the next accepted value through shift-and-add-3 conversion at four
// magnitude bits per cycle, a state that finds the leading digit, the characters one by one
// through the output register, held back while out_ready is low, and the idle state in which
// the next value is taken. The text of a value is 1 to 11 characters long. The next value is
// accepted while the closing character still waits in the output register. MAX_DIGITS sets
// the digit buffer; a magnitude that needs more digits prints as MAX_DIGITS nines with its
// sign kept.
module signed_binary_to_decimal_ascii_core
    import sb2dec_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  character,
    output logic               last,
    output logic [COUNT_W-1:0] char_count
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    sb2dec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sb2dec_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .last       (last),
        .char_count (char_count)
    );

endmodule

// ----- bench/tb.sv -----
import sb2dec_pkg::*;

// One character beat of a printed run, as the output side should carry it.
typedef struct {
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic [COUNT_W-1:0] count;
} text_beat_t;

// Holds the characters still owed by the block and checks each one that arrives.
class decimal_text_board;
    int unsigned max_digits;
    int unsigned mismatches;
    text_beat_t  pending_beats[$];

    function new(int unsigned max_digits);
        this.max_digits = max_digits;
        mismatches = 0;
        pending_beats.delete();
    endfunction

    // Spells out an accepted value in decimal and queues the run of characters it should give.
    function void note_value(logic [VALUE_W-1:0] v);
        logic               neg;
        logic [VALUE_W-1:0] negated;
        logic [63:0]        mag;
        logic [63:0]        cap;
        int unsigned        width;
        int unsigned        digs[20];
        int                 nd;
        int                 total;
        text_beat_t         b;
        neg = v[VALUE_W-1];
        negated = -v;
        mag = neg ? {{(64-VALUE_W){1'b0}}, negated} : {{(64-VALUE_W){1'b0}}, v};

        // A magnitude wider than the digit buffer saturates to all nines.
        width = (max_digits < 1) ? 1 : ((max_digits > 19) ? 19 : max_digits);
        cap = 64'd1;
        repeat (width)
        begin
            cap = cap * 64'd10;
        end
        cap = cap - 64'd1;
        if (mag > cap)
        begin
            mag = cap;
        end

        // Digits are gathered least significant first.
        nd = 0;
        if (mag == 64'd0)
        begin
            digs[0] = 0;
            nd = 1;
        end
        else
        begin
            while (mag != 64'd0 && nd < 20)
            begin
                digs[nd] = int'(mag % 64'd10);
                mag = mag / 64'd10;
                nd++;
            end
        end
        total = nd + (neg ? 1 : 0);

        if (neg)
        begin
            b.character = CHAR_MINUS;
            b.last = 1'b0;
            b.count = '0;
            pending_beats.push_back(b);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            b.character = CHAR_ZERO + CHAR_W'(digs[i]);
            b.last = (i == 0);
            b.count = (i == 0) ? COUNT_W'(total) : '0;
            pending_beats.push_back(b);
        end
    endfunction

    // Compares an accepted output beat with the oldest character still owed.
    function void check_beat(logic [CHAR_W-1:0] c, logic l, logic [COUNT_W-1:0] n);
        text_beat_t want;
        if (pending_beats.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Unexpected beat: character %0d last %0d count %0d", c, l, n);
            end
            return;
        end
        want = pending_beats.pop_front();
        if (c !== want.character || l !== want.last || n !== want.count)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Mismatch: expected character %0d last %0d count %0d, got %0d %0d %0d",
                         want.character, want.last, want.count, c, l, n);
            end
        end
    endfunction

    function int unsigned outstanding();
        return pending_beats.size();
    endfunction
endclass

module tb;

    localparam int DIGITS      = MAX_DIGITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int RANDOM_ITEMS = 390;

    // Extremes of the range, digit-count boundaries, both signs and zero.
    localparam longint DIRECTED [22] = '{
        0, 1, -1, 9, -9, 10, 99, 100, -100, 123456789, 999999999, 1000000000,
        -1000000000, 2147483647, -2147483648, 64'sd2147483648, 64'sd4294967295,
        -64'sd2147483649, -64'sd4294967295, -64'sd4294967296, 64'h0_AAAA_AAAA,
        64'h1_5555_5555
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [VALUE_W-1:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic [COUNT_W-1:0] char_count;

    decimal_text_board board;
    int unsigned       cycles = 0;
    bit                sender_calm = 1'b0;

    always #5 clk = ~clk;

    signed_binary_to_decimal_ascii_core #(
        .MAX_DIGITS (DIGITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .last       (last),
        .char_count (char_count)
    );

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one value, waits for its beat to be taken, then idles for a drawn gap.
    task automatic offer_value(input logic [VALUE_W-1:0] v);
        int unsigned gap;
        in_valid <= 1'b1;
        value <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        board.note_value(v);
        gap = sender_calm ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every owed character has come out.
    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (board.outstanding() != 0);
    endtask

    // Draws a value: mostly a random digit count, some raw patterns, some near powers of ten.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned        kind;
        int unsigned        nd;
        logic [63:0]        lo;
        logic [63:0]        hi;
        logic [63:0]        mag;
        logic [VALUE_W-1:0] v;
        kind = $urandom_range(0, 9);
        if (kind >= 6 && kind < 8)
        begin
            return {1'($urandom_range(0, 1)), 32'($urandom())};
        end
        if (kind < 6)
        begin
            nd = $urandom_range(1, 10);
            lo = 64'd1;
            repeat (nd - 1)
            begin
                lo = lo * 64'd10;
            end
            hi = lo * 64'd10 - 64'd1;
            if (nd == 1)
            begin
                lo = 64'd0;
            end
            if (hi > 64'hFFFF_FFFF)
            begin
                hi = 64'hFFFF_FFFF;
            end
            mag = lo + {32'($urandom()), 32'($urandom())} % (hi - lo + 64'd1);
        end
        else
        begin
            mag = 64'd1;
            repeat ($urandom_range(0, 9))
            begin
                mag = mag * 64'd10;
            end
            mag = mag - 64'd1 + 64'($urandom_range(0, 2));
        end
        v = mag[VALUE_W-1:0];
        if ($urandom_range(0, 1) == 1)
        begin
            v = -v;
        end
        return v;
    endfunction

    // Output side: random stalls, calm stretches, and one long hold-off so the block backs up.
    initial
    begin : receiver
        int unsigned beats;
        int unsigned stall;
        bit          calm;
        beats = 0;
        calm = 1'b0;
        // Nothing is sampled until the block has come out of reset.
        wait (rst_n === 1'b1);
        forever
        begin
            if (beats % 25 == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
            end
            stall = calm ? 0 : $urandom_range(0, 12);
            if (beats == 120)
            begin
                stall = LONG_HOLD;
            end
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            board.check_beat(character, last, char_count);
            beats++;
        end
    end

    // Input side: reset, directed values, then random values with one full drain midway.
    initial
    begin : sender
        board = new(DIGITS);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            offer_value(VALUE_W'(DIRECTED[i]));
        end
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 20 == 0)
            begin
                sender_calm = ($urandom_range(0, 2) == 0);
            end
            if (n == 200)
            begin
                drain();
            end
            offer_value(pick_value());
        end
        drain();
        repeat (40) @(posedge clk);

        if (board.mismatches == 0 && board.outstanding() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
